/* sv/ouvs_pkg.sv */
// Package for the ordered unique value set: item payloads, command codes,
// controller states and the control and status bundles between controller and datapath.
// No dependencies.
package ouvs_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_READ   = 2'd3
	} command_t;

	typedef struct packed {
		command_t           command;
		logic signed [31:0] value;
		logic [3:0]         position;
	} cmd_item_t;

	typedef struct packed {
		logic               was_present;
		logic [4:0]         entry_count;
		logic signed [31:0] read_data;
		logic               read_valid;
		logic               add_refused;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	// RAM read address select
	typedef enum logic [1:0] {
		RD_POS,
		RD_ZERO,
		RD_NEXT,
		RD_NEXT2
	} rd_sel_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC
	} idx_op_t;

	typedef struct packed {
		logic    latch;
		rd_sel_t rd_sel;
		idx_op_t idx_op;
		logic    wr_append;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    res_stage;
		logic    res_present;
		logic    res_refused;
		logic    res_rvalid;
		logic    out_load;
	} ctrl_t;

	typedef struct packed {
		command_t command;
		logic     empty;
		logic     full;
		logic     pos_ok;
		logic     hit;
		logic     last;
		logic     shift_last;
		logic     out_free;
	} status_t;

endpackage

/* sv/ouvs_chan_if.sv */
// Valid/ready channel interface carrying one item of payload type T.
// No dependencies; the payload type comes from ouvs_pkg at instantiation.
interface ouvs_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/ouvs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ouvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* sv/ouvs_ctrl.sv */
// Controller for the ordered unique value set: sequences dispatch, scan,
// shift compaction, entry read and result hand-off. Depends on ouvs_pkg.
module ouvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ouvs_pkg::status_t sts,
	output ouvs_pkg::ctrl_t   ctl
);
	import ouvs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.rd_sel = RD_NEXT;
		ctl.idx_op = IDX_HOLD;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctl.latch = in_valid;
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.command == CMD_READ) begin
					if (sts.pos_ok) begin
						ctl.rd_sel = RD_POS;
						state_d    = ST_RDWAIT;
					end else begin
						ctl.res_stage = 1'b1;
						state_d       = ST_DONE;
					end
				end else if (sts.empty) begin
					// empty store: lookup misses at once
					ctl.res_stage = 1'b1;
					if (sts.command == CMD_ADD) begin
						ctl.wr_append = 1'b1;
						ctl.cnt_inc   = 1'b1;
					end
					state_d = ST_DONE;
				end else begin
					ctl.rd_sel = RD_ZERO;
					ctl.idx_op = IDX_CLR;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// keep the next entry read in flight; it feeds the first shift step too
				ctl.rd_sel = RD_NEXT;
				if (sts.hit) begin
					ctl.res_stage   = 1'b1;
					ctl.res_present = 1'b1;
					if (sts.command == CMD_REMOVE && !sts.last) begin
						state_d = ST_SHIFT;
					end else begin
						ctl.cnt_dec = (sts.command == CMD_REMOVE);
						state_d     = ST_DONE;
					end
				end else if (sts.last) begin
					ctl.res_stage = 1'b1;
					if (sts.command == CMD_ADD) begin
						if (sts.full) begin
							ctl.res_refused = 1'b1;
						end else begin
							ctl.wr_append = 1'b1;
							ctl.cnt_inc   = 1'b1;
						end
					end
					state_d = ST_DONE;
				end else begin
					ctl.idx_op = IDX_INC;
				end
			end
			ST_SHIFT: begin
				// move the entry above down by one place
				ctl.wr_shift = 1'b1;
				ctl.rd_sel   = RD_NEXT2;
				if (sts.shift_last) begin
					ctl.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end else begin
					ctl.idx_op = IDX_INC;
				end
			end
			ST_RDWAIT: begin
				ctl.res_stage  = 1'b1;
				ctl.res_rvalid = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* sv/ouvs_dpath.sv */
// Datapath for the ordered unique value set: entry RAM, count, scan index,
// captured item, staged result and output register. Depends on ouvs_pkg, ouvs_ram.
module ouvs_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ouvs_pkg::ctrl_t     ctl,
	output ouvs_pkg::status_t   sts,
	input  ouvs_pkg::cmd_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ouvs_pkg::res_item_t out_item
);
	import ouvs_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	command_t           command_q;
	logic signed [31:0] value_q;
	logic [3:0]         position_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [CW:0]        idx_x;
	logic [CW:0]        count_x;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [IW-1:0] rd_addr;
	logic [31:0]   rd_data;

	logic        present_q;
	logic        refused_q;
	logic        rvalid_q;
	logic [31:0] rdata_q;
	logic        out_valid_q;

	assign idx_x   = (CW + 1)'(idx_q);
	assign count_x = (CW + 1)'(count_q);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			command_q  <= in_item.command;
			value_q    <= in_item.value;
			position_q <= in_item.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			case (ctl.idx_op)
				IDX_CLR: idx_q <= '0;
				IDX_INC: idx_q <= idx_q + IW'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_comb begin
		unique case (ctl.rd_sel)
			RD_POS:   rd_addr = IW'(position_q);
			RD_ZERO:  rd_addr = '0;
			RD_NEXT:  rd_addr = IW'(idx_x + (CW + 1)'(1));
			RD_NEXT2: rd_addr = IW'(idx_x + (CW + 1)'(2));
			default:  rd_addr = '0;
		endcase
	end

	assign wr_en   = ctl.wr_append | ctl.wr_shift;
	assign wr_addr = ctl.wr_shift ? idx_q : IW'(count_q);
	assign wr_data = ctl.wr_shift ? rd_data : value_q;

	ouvs_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (ctl.res_stage) begin
			present_q <= ctl.res_present;
			refused_q <= ctl.res_refused;
			rvalid_q  <= ctl.res_rvalid;
			rdata_q   <= ctl.res_rvalid ? rd_data : 32'd0;
		end
		if (ctl.out_load) begin
			out_item.was_present <= present_q;
			out_item.entry_count <= 5'(count_q);
			out_item.read_data   <= rdata_q;
			out_item.read_valid  <= rvalid_q;
			out_item.add_refused <= refused_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.command    = command_q;
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == CW'(CAPACITY));
	assign sts.pos_ok     = (PW'(position_q) < PW'(count_q));
	assign sts.hit        = (rd_data == value_q);
	assign sts.last       = ((idx_x + (CW + 1)'(1)) == count_x);
	assign sts.shift_last = ((idx_x + (CW + 1)'(2)) == count_x);
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule

/* sv/ordered_unique_value_set.sv */
// A read goes from dispatch through a RAM read wait to done, or straight to done when the position
// is at or past the count. Query, add and remove scan the entries (none if empty); a remove that
// hits below the last entry then shifts the entries above it down. A stalled result keeps it in done.
// Throughput: one item at a time; scan and compaction cover one entry a cycle, set by the single
// RAM read port. Reset (arst_n low, asynchronous) empties the store and drops a pending result;
// the entry RAM is not cleared. Depends on ouvs_pkg, ouvs_chan_if, ouvs_ctrl, ouvs_dpath, ouvs_ram.
module ordered_unique_value_set_core #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ouvs_chan_if.sink   cmd,
	ouvs_chan_if.source res
);
	import ouvs_pkg::*;

	// controller and datapath meet only through these two bundles
	ctrl_t   ctl;
	status_t sts;

	// one command in flight: the controller takes an item only from idle,
	// while the output register may still hold the previous result
	ouvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// entries live in a RAM in insertion order; positions below the count are valid,
	// so an unwritten entry is never compared or returned
	ouvs_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_item   (cmd.payload),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_item  (res.payload)
	);
endmodule

/* sv/ouvs_chk.sv */
// Port-level checker for ordered_unique_value_set_core, with its bind statement.
// Depends on ouvs_pkg.
module ouvs_chk #(
	parameter int CAPACITY = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                res_valid,
	input logic                res_ready,
	input ouvs_pkg::res_item_t res_item
);
	import ouvs_pkg::*;

	// hold a pending result and its payload until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result dropped or changed while stalled");

	// one command at a time: no second accept right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in flight");

	// a refused add means the store was full and the value absent
	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.add_refused |->
			!res_item.was_present && !res_item.read_valid &&
			res_item.entry_count == 5'(CAPACITY))
		else $error("add refused without a full store");

	// read data is zero unless a valid read returned it
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.read_valid |-> res_item.read_data == 32'sd0)
		else $error("read data nonzero without valid read");

	// a valid read does no lookup
	a_read_no_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.read_valid |-> !res_item.was_present)
		else $error("read result flags presence");
endmodule

bind ordered_unique_value_set_core ouvs_chk #(
	.CAPACITY(CAPACITY)
) u_ouvs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.payload)
);

/* sim/ordered_unique_value_set_core_tb.sv */
// Testbench for ordered_unique_value_set_core: drives commands, mirrors the set in a predictor
// and checks every result item field by field, in order.
// Depends on ouvs_pkg, ouvs_chan_if and the block's RTL.
`timescale 1ns / 1ps

module ordered_unique_value_set_core_tb;
	import ouvs_pkg::*;

	localparam int SET_CAPACITY = 16;
	localparam int POOL_SIZE    = 24;
	localparam int CYCLE_LIMIT  = 600000;
	// margin for a command that walks the whole store, such as a remove, to finish
	localparam int DRAIN_CYCLES = 3 * (SET_CAPACITY + 4);
	localparam int HOLD_LEN     = 400;

	logic clk;
	logic arst_n;

	ouvs_chan_if #(.T(cmd_item_t)) cmd_ch ();
	ouvs_chan_if #(.T(res_item_t)) res_ch ();

	ordered_unique_value_set_core #(
		.CAPACITY(SET_CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// Mirror of the set: entries in insertion order and the entry count.
	logic signed [31:0] set_mem [SET_CAPACITY];
	int                 set_count;

	res_item_t          expected_results [$];
	logic signed [31:0] value_pool [POOL_SIZE];

	int mismatches;
	int result_index;
	int cycle_count;
	// percentage of cycles in which each side idles; zero gives a steady flow
	int idle_pct;
	// long receiver hold-offs: requested by a test, served by the receiver process
	int hold_requests;
	int hold_served;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Predict the result of one command and advance the mirrored set.
	function automatic res_item_t next_set_result(input cmd_item_t c);
		res_item_t r;
		int        hit_idx;
		r = '0;
		hit_idx = -1;
		for (int i = 0; i < set_count; i++) begin
			if (hit_idx < 0 && set_mem[i] == c.value) begin
				hit_idx = i;
			end
		end
		case (c.command)
			CMD_ADD: begin
				r.was_present = (hit_idx >= 0);
				if (hit_idx < 0) begin
					if (set_count < SET_CAPACITY) begin
						set_mem[set_count] = c.value;
						set_count++;
					end else begin
						// absent value, no room: refuse and leave the set alone
						r.add_refused = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				r.was_present = (hit_idx >= 0);
				if (hit_idx >= 0) begin
					// close the gap so insertion order survives
					for (int i = hit_idx; i + 1 < set_count; i++) begin
						set_mem[i] = set_mem[i + 1];
					end
					set_count--;
				end
			end
			CMD_QUERY: begin
				r.was_present = (hit_idx >= 0);
			end
			CMD_READ: begin
				// no lookup on a read, so was_present stays low
				if (int'(c.position) < set_count) begin
					r.read_valid = 1'b1;
					r.read_data  = set_mem[c.position];
				end
			end
		endcase
		r.entry_count = 5'(set_count);
		return r;
	endfunction

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d arrived with nothing expected: count=%0d data=%0d",
					result_index, got.entry_count, got.read_data);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.was_present !== want.was_present || got.entry_count !== want.entry_count ||
					got.read_data !== want.read_data || got.read_valid !== want.read_valid ||
					got.add_refused !== want.add_refused) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"result %0d mismatch: expected present=%0b count=%0d",
						" data=%0d rvalid=%0b refused=%0b"},
						result_index, want.was_present, want.entry_count, want.read_data,
						want.read_valid, want.add_refused);
					$display({"result %0d mismatch:      got present=%0b count=%0d",
						" data=%0d rvalid=%0b refused=%0b"},
						result_index, got.was_present, got.entry_count, got.read_data,
						got.read_valid, got.add_refused);
				end
			end
		end
		result_index++;
	endtask

	// Sample both channels at the edge: check results first, then queue the prediction of a
	// newly accepted command. Results always arrive after their command is accepted.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				check_result(res_ch.payload);
			end
			if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
				expected_results = {expected_results, next_set_result(cmd_ch.payload)};
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long counted stretch when a test asks.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served < hold_requests) begin
				res_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_LEN; n++) begin
					@(posedge clk);
				end
				hold_served++;
			end
			res_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	function automatic cmd_item_t make_item(input command_t op, input logic signed [31:0] v,
			input logic [3:0] p);
		cmd_item_t c;
		c.command  = op;
		c.value    = v;
		c.position = p;
		return c;
	endfunction

	// Offer one item, with a random gap before it, and hold it until it is accepted.
	task automatic send_command(input cmd_item_t c);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
	endtask

	// Draw a command with the given mix. Values come mostly from a small pool or from the
	// mirrored set, so hits, duplicates and a full store are common; a few are fully random.
	function automatic cmd_item_t random_command(input int add_pct, input int remove_pct,
			input int query_pct);
		cmd_item_t c;
		int        pick;
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			c.command = CMD_ADD;
		end else if (pick < add_pct + remove_pct) begin
			c.command = CMD_REMOVE;
		end else if (pick < add_pct + remove_pct + query_pct) begin
			c.command = CMD_QUERY;
		end else begin
			c.command = CMD_READ;
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			c.value = $urandom;
		end else if (pick < 40 && set_count > 0) begin
			c.value = set_mem[$urandom_range(set_count - 1)];
		end else begin
			c.value = value_pool[$urandom_range(POOL_SIZE - 1)];
		end
		if (set_count > 0 && $urandom_range(1) == 1) begin
			c.position = 4'($urandom_range(set_count - 1));
		end else begin
			c.position = 4'($urandom_range(15));
		end
		return c;
	endfunction

	// Extremes, every command and the corner cases: empty store, duplicate add, absent
	// remove, full store refusal versus duplicate add at full, reads past the count.
	task automatic test_directed_cases();
		send_command(make_item(CMD_QUERY, 32'sd0, 4'd0));
		send_command(make_item(CMD_READ, 32'sd0, 4'd0));
		send_command(make_item(CMD_REMOVE, 32'sd7, 4'd0));
		send_command(make_item(CMD_ADD, 32'h8000_0000, 4'd0));
		send_command(make_item(CMD_ADD, 32'h7fff_ffff, 4'd0));
		send_command(make_item(CMD_ADD, 32'sd0, 4'd0));
		send_command(make_item(CMD_ADD, -32'sd1, 4'd0));
		send_command(make_item(CMD_ADD, 32'h7fff_ffff, 4'd0));
		send_command(make_item(CMD_QUERY, -32'sd1, 4'd0));
		send_command(make_item(CMD_REMOVE, 32'sd0, 4'd0));
		send_command(make_item(CMD_READ, 32'sd0, 4'd2));
		send_command(make_item(CMD_READ, 32'sd0, 4'd3));
		// fill the store to capacity with distinct values
		for (int i = 0; i < SET_CAPACITY - 3; i++) begin
			send_command(make_item(CMD_ADD, 32'h1234_5678 + i * 32'h0101_0101, 4'd0));
		end
		send_command(make_item(CMD_ADD, 32'sd42, 4'd0));
		send_command(make_item(CMD_ADD, 32'h8000_0000, 4'd0));
		send_command(make_item(CMD_READ, 32'sd0, 4'd15));
		send_command(make_item(CMD_REMOVE, 32'h8000_0000, 4'd0));
		send_command(make_item(CMD_READ, 32'hffff_ffff, 4'd15));
		send_command(make_item(CMD_REMOVE, 32'h1234_5678 + 12 * 32'h0101_0101, 4'd0));
		send_command(make_item(CMD_READ, 32'sd0, 4'd0));
	endtask

	task automatic test_random_mix(input int items);
		for (int n = 0; n < items; n++) begin
			send_command(random_command(35, 25, 20));
		end
	endtask

	// No idling on either side: back-to-back commands and results.
	task automatic test_steady_flow(input int items);
		idle_pct = 0;
		test_random_mix(items);
		idle_pct = 30;
	endtask

	// Hold results off for a long stretch while commands keep coming, so the block backs up.
	task automatic test_result_backpressure(input int items);
		idle_pct = 0;
		hold_requests++;
		test_random_mix(items);
		idle_pct = 30;
	endtask

	// Sweep the count up to full and back down to empty several times.
	task automatic test_fill_and_drain(input int rounds);
		for (int r = 0; r < rounds; r++) begin
			for (int n = 0; n < 50; n++) begin
				send_command(random_command(70, 10, 10));
			end
			for (int n = 0; n < 50; n++) begin
				send_command(random_command(5, 75, 10));
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		set_count     = 0;
		mismatches    = 0;
		result_index  = 0;
		cycle_count   = 0;
		idle_pct      = 30;
		hold_requests = 0;
		hold_served   = 0;
		for (int i = 0; i < SET_CAPACITY; i++) begin
			set_mem[i] = '0;
		end
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) begin
			value_pool[i] = $urandom;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_mix(600);
		test_steady_flow(300);
		test_result_backpressure(80);
		test_fill_and_drain(5);
		test_random_mix(100);

		// drop valid after the last item and let the block drain
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/ouvs_pkg.sv
sv/ouvs_chan_if.sv
sv/ouvs_ram.sv
sv/ouvs_ctrl.sv
sv/ouvs_dpath.sv
sv/ordered_unique_value_set.sv
sv/ouvs_chk.sv
sim/ordered_unique_value_set_core_tb.sv
